FILE: rtl/whole_word_stream_remover_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the whole-word stream remover
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_STREAM_REMOVER_MACROS_SVH
`define WHOLE_WORD_STREAM_REMOVER_MACROS_SVH

// same-cycle implication
`define WWSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wwsr check failed");

// next-cycle implication
`define WWSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wwsr check failed");

`endif

FILE: rtl/wwsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwsr_pkg
// Shared constants, codes and types of the whole-word stream remover.
// ----------------------------------------------------------------------------
package wwsr_pkg;

  localparam int MAX_WORD  = 32;
  localparam int FILL_W    = $clog2(MAX_WORD + 1);
  localparam int IDX_W     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int TL_W      = 6;
  localparam int TGT_REGS  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int CNT_W     = 32;
  localparam int OUT_DAT_W = 40;
  localparam int OUT_USR_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTES0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTES1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTES2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BYTES3 = 3'd4;

  localparam logic [7:0] SEP_SPACE   = 8'h20;
  localparam logic [7:0] SEP_NEWLINE = 8'h0a;
  localparam logic [7:0] SEP_TAB     = 8'h09;
  localparam logic [7:0] SEP_PERIOD  = 8'h2e;
  localparam logic [7:0] SEP_COMMA   = 8'h2c;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EOS,
    ST_FLUSH_B,
    ST_FLUSH_T,
    ST_BYTE,
    ST_TRAIL
  } wwsr_state_e;

  typedef struct packed {
    logic accept;
    logic clr_pt;
    logic set_pt;
    logic store;
    logic drop;
    logic flush_start;
    logic emit_flush;
    logic emit_byte;
    logic emit_trail;
  } wwsr_cmd_t;

  typedef struct packed {
    logic is_sep;
    logic pass;
    logic fill_zero;
    logic room;
    logic match;
    logic flush_last;
    logic eos;
    logic out_free;
  } wwsr_stat_t;

endpackage

FILE: rtl/whole_word_stream_remover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_stream_remover
// Drops whole words equal to a configured target from a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A byte that joins the held word is stored; a
// separator or pass-through byte is sent from ST_BYTE, after any flush that
// sends each held byte. End of stream adds a trailer, with ST_EOS before it
// unless the last byte was a word byte passed straight through. The single
// output register takes one result per cycle unless m_axis_tready stalls it.
// The user writes the target word and length through the cfg port (index 0
// length, 1 to 4 target bytes, lowest byte first) only while no byte is in
// flight; the block does not enforce this. The trailer carries the
// removed-word count and clears it.
// ----------------------------------------------------------------------------
module whole_word_stream_remover
  import wwsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // data_byte
  input  logic                 s_axis_tlast,   // end_of_stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DAT_W-1:0] m_axis_tdata,   // out_byte[7:0], removed_count[39:8]
  output logic [OUT_USR_W-1:0] m_axis_tuser,   // has_byte[0], stream_done[1]
  output logic                 m_axis_tlast,   // run_last
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  wwsr_cmd_t  cmd;
  wwsr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  wwsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wwsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser),
    .m_last_o    (m_axis_tlast)
  );

endmodule

FILE: rtl/wwsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwsr_datapath
// Target registers, word store, match compare, tally and output register.
// ----------------------------------------------------------------------------
module wwsr_datapath
  import wwsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           in_data_i,
  input  logic                 in_last_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wwsr_cmd_t            cmd_i,
  output wwsr_stat_t           stat_o,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic [OUT_DAT_W-1:0] m_data_o,   // out_byte, removed_count
  output logic [OUT_USR_W-1:0] m_user_o,   // has_byte, stream_done
  output logic                 m_last_o    // run_last
);

  logic [TL_W-1:0]      tlen_q;
  logic [CFG_DAT_W-1:0] target_q [TGT_REGS];
  logic [7:0]           store_q  [MAX_WORD];
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]     idx_q;
  logic                 pt_q, pt_d;
  logic [CNT_W-1:0]     tally_q, tally_d;
  logic [7:0]           byte_q;
  logic                 eos_q;

  logic                 m_valid_q, m_valid_d;
  logic [7:0]           o_byte_q;
  logic [CNT_W-1:0]     o_cnt_q;
  logic                 o_has_q, o_done_q, o_last_q;

  logic [TL_W-1:0]      lim;
  logic                 bytes_eq;
  logic                 is_sep;
  logic                 load;

  // target length outside 1..MAX_WORD never matches
  assign lim = (tlen_q != '0 && tlen_q <= TL_W'(MAX_WORD)) ? tlen_q : '0;

  assign is_sep = (byte_q == SEP_SPACE) || (byte_q == SEP_NEWLINE) ||
                  (byte_q == SEP_TAB) || (byte_q == SEP_PERIOD) ||
                  (byte_q == SEP_COMMA);

  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (FILL_W'(i) < fill_q && store_q[i] != target_q[i / 8][(i % 8) * 8 +: 8]) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign stat_o.is_sep     = is_sep;
  assign stat_o.pass       = pt_q;
  assign stat_o.fill_zero  = (fill_q == '0);
  assign stat_o.room       = (TL_W'(fill_q) < lim);
  assign stat_o.match      = (lim != '0) && (TL_W'(fill_q) == lim) && bytes_eq;
  assign stat_o.flush_last = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
  assign stat_o.eos        = eos_q;
  assign stat_o.out_free   = !m_valid_q || m_ready_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q <= TL_W'(1);
      for (int r = 0; r < TGT_REGS; r++) begin
        target_q[r] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TARGET_LENGTH: tlen_q      <= cfg_data_i[TL_W-1:0];
        REG_TARGET_BYTES0: target_q[0] <= cfg_data_i;
        REG_TARGET_BYTES1: target_q[1] <= cfg_data_i;
        REG_TARGET_BYTES2: target_q[2] <= cfg_data_i;
        REG_TARGET_BYTES3: target_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input byte and word store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i;
      eos_q  <= in_last_i;
    end
    if (cmd_i.store) begin
      store_q[fill_q[IDX_W-1:0]] <= byte_q;
    end
    if (cmd_i.flush_start) begin
      idx_q <= '0;
    end else if (cmd_i.emit_flush) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    fill_d  = fill_q;
    pt_d    = pt_q;
    tally_d = tally_q;
    if (cmd_i.store) begin
      fill_d = fill_q + FILL_W'(1);
    end
    if (cmd_i.drop) begin
      fill_d = '0;
      if (tally_q != '1) begin
        tally_d = tally_q + CNT_W'(1);
      end
    end
    if (cmd_i.emit_flush && stat_o.flush_last) begin
      fill_d = '0;
    end
    if (cmd_i.set_pt) begin
      pt_d = 1'b1;
    end
    if (cmd_i.clr_pt) begin
      pt_d = 1'b0;
    end
    if (cmd_i.emit_trail) begin
      fill_d  = '0;
      pt_d    = 1'b0;
      tally_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pt_q    <= 1'b0;
      tally_q <= '0;
    end else begin
      fill_q  <= fill_d;
      pt_q    <= pt_d;
      tally_q <= tally_d;
    end
  end

  // output register
  assign load = cmd_i.emit_flush || cmd_i.emit_byte || cmd_i.emit_trail;

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_flush) begin
      o_byte_q <= store_q[idx_q];
      o_cnt_q  <= '0;
      o_has_q  <= 1'b1;
      o_done_q <= 1'b0;
      o_last_q <= 1'b0;
    end else if (cmd_i.emit_byte) begin
      o_byte_q <= byte_q;
      o_cnt_q  <= '0;
      o_has_q  <= 1'b1;
      o_done_q <= 1'b0;
      o_last_q <= !eos_q;
    end else if (cmd_i.emit_trail) begin
      o_byte_q <= '0;
      o_cnt_q  <= tally_q;
      o_has_q  <= 1'b0;
      o_done_q <= 1'b1;
      o_last_q <= 1'b1;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {o_cnt_q, o_byte_q};
  assign m_user_o  = {o_done_q, o_has_q};
  assign m_last_o  = o_last_q;

endmodule

FILE: rtl/wwsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwsr_ctrl
// Sequencer: classifies each byte, steps flushes, byte and trailer output.
// ----------------------------------------------------------------------------
module wwsr_ctrl
  import wwsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  wwsr_stat_t stat_i,
  output wwsr_cmd_t  cmd_o
);

  wwsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.is_sep) begin
          if (stat_i.pass || stat_i.fill_zero || stat_i.match) state_d = ST_BYTE;
          else state_d = ST_FLUSH_B;
        end else if (stat_i.pass) begin
          state_d = ST_BYTE;
        end else if (stat_i.room) begin
          state_d = stat_i.eos ? ST_EOS : ST_IDLE;
        end else begin
          state_d = stat_i.fill_zero ? ST_BYTE : ST_FLUSH_B;
        end
      end
      ST_EOS: begin
        if (stat_i.fill_zero || stat_i.match) state_d = ST_TRAIL;
        else state_d = ST_FLUSH_T;
      end
      ST_FLUSH_B: begin
        if (stat_i.out_free && stat_i.flush_last) state_d = ST_BYTE;
      end
      ST_FLUSH_T: begin
        if (stat_i.out_free && stat_i.flush_last) state_d = ST_TRAIL;
      end
      ST_BYTE: begin
        if (stat_i.out_free) begin
          if (!stat_i.eos) state_d = ST_IDLE;
          else state_d = stat_i.pass ? ST_TRAIL : ST_EOS;
        end
      end
      ST_TRAIL: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECIDE: begin
        if (stat_i.is_sep) begin
          if (stat_i.pass) cmd_o.clr_pt = 1'b1;
          else if (stat_i.fill_zero) cmd_o.drop = 1'b0;
          else if (stat_i.match) cmd_o.drop = 1'b1;
          else cmd_o.flush_start = 1'b1;
        end else if (!stat_i.pass) begin
          if (stat_i.room) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.set_pt      = 1'b1;
            cmd_o.flush_start = !stat_i.fill_zero;
          end
        end
      end
      ST_EOS: begin
        if (!stat_i.fill_zero) begin
          if (stat_i.match) cmd_o.drop = 1'b1;
          else cmd_o.flush_start = 1'b1;
        end
      end
      ST_FLUSH_B, ST_FLUSH_T: cmd_o.emit_flush = stat_i.out_free;
      ST_BYTE:                cmd_o.emit_byte  = stat_i.out_free;
      ST_TRAIL:               cmd_o.emit_trail = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/wwsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwsr_checker
// Port-level checks on the whole-word stream remover, bound to the top.
// ----------------------------------------------------------------------------
`include "whole_word_stream_remover_macros.svh"

module wwsr_checker
  import wwsr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_DAT_W-1:0] m_axis_tdata,
  input logic [OUT_USR_W-1:0] m_axis_tuser,
  input logic                 m_axis_tlast
);

  // stalled result holds
  `WWSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // trailer closes the run and carries no byte
  `WWSR_ASSERT_NOW(a_trailer, m_axis_tvalid && m_axis_tuser[1],
    m_axis_tlast && !m_axis_tuser[0] && m_axis_tdata[7:0] == 8'h00)

  // data bytes carry a zero count and are never the trailer
  `WWSR_ASSERT_NOW(a_data_byte, m_axis_tvalid && m_axis_tuser[0],
    !m_axis_tuser[1] && m_axis_tdata[OUT_DAT_W-1:8] == '0)

  // each result is either a byte or the trailer
  `WWSR_ASSERT_NOW(a_kind, m_axis_tvalid, m_axis_tuser[0] != m_axis_tuser[1])

  // a taken byte is decided before the next transfer
  `WWSR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind whole_word_stream_remover wwsr_checker u_wwsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
